>>> design/tx_ring_buffer_dma_chunker_macros.svh
// assertion macros used by the checker file
`ifndef TX_RING_BUFFER_DMA_CHUNKER_MACROS_SVH
`define TX_RING_BUFFER_DMA_CHUNKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TXRB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TXRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/txrb_pkg.sv
// shared types and constants for the transmit ring buffer dma chunker
package txrb_pkg;

	// fixed field widths
	localparam int FUNC_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 12;
	localparam int LENGTH_W = 13;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// length of the overflow warning message
	localparam logic [LENGTH_W-1:0] WARN_LENGTH = 13'd26;

	// control sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_READ
	} txrb_state_t;

endpackage

>>> design/tx_ring_buffer_dma_chunker.sv
// transmit ring buffer that schedules contiguous dma bursts
// Transmit ring buffer in front of a DMA engine. Each accepted beat on the item
// channel gives exactly one beat on the result channel. Write, transfer-done and
// unused-code beats need no read state, so back-to-back writes stream at one per
// clock while the result side keeps up; a read passes through ST_READ because
// the byte store is a single-port memory with a registered read port, and the
// item channel stalls while the read data is on its way out. The result
// register lets the next beat in while the last result is being taken. There is
// no clearing pass after reset: the byte store holds whatever it held until
// written, and a read of a byte never written returns an arbitrary value.
module tx_ring_buffer_dma_chunker #(
	parameter int BUFFER_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [txrb_pkg::FUNC_W-1:0]     func,
	input  logic [txrb_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            end_of_write,
	input  logic [txrb_pkg::OFFSET_W-1:0]   read_address,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            write_accepted,
	output logic                            overflow_flag,
	output logic                            start_burst,
	output logic                            burst_is_message,
	output logic [txrb_pkg::OFFSET_W-1:0]   burst_offset,
	output logic [txrb_pkg::LENGTH_W-1:0]   burst_length,
	output logic [txrb_pkg::BYTE_W-1:0]     read_data
);
	import txrb_pkg::*;

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int LEN_W = PTR_W + 1;
	localparam int AW    = (PTR_W > OFFSET_W) ? PTR_W : OFFSET_W;

	// byte store and its registered read port
	logic [BYTE_W-1:0] byte_store_mem [BUFFER_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_addr;

	// control state
	txrb_state_t      state_q, state_d;
	logic [PTR_W-1:0] wp_q, wp_d;
	logic [PTR_W-1:0] rp_q, rp_d;
	logic [PTR_W-1:0] snap_q, snap_d;
	logic             running_q, running_d;
	logic             ovf_q, ovf_d;
	logic             warn_q, warn_d;
	logic             rd_in_range_q;

	// result register
	logic                res_valid_q;
	logic                res_wr_acc_q;
	logic                res_ovf_q;
	logic                res_start_q;
	logic                res_msg_q;
	logic [OFFSET_W-1:0] res_offset_q;
	logic [LENGTH_W-1:0] res_length_q;
	logic [BYTE_W-1:0]   res_rdata_q;

	logic                out_load;
	logic                nx_wr_acc;
	logic                nx_ovf;
	logic                nx_start;
	logic                nx_msg;
	logic [OFFSET_W-1:0] nx_offset;
	logic [LENGTH_W-1:0] nx_length;
	logic [BYTE_W-1:0]   nx_rdata;

	logic accept;

	// decode of the item and pointer candidates
	logic             is_write, is_done, is_read;
	logic [PTR_W-1:0] wp_inc;
	logic             wr_hit;
	logic [PTR_W-1:0] done_rp;
	logic             wr_ok, done_msg, done_adv;
	logic [AW-1:0]    addr_wide;
	logic             rd_in_range;
	logic [PTR_W-1:0] rd_index;

	// shared burst scheduler inputs and outputs
	logic             sched_try;
	logic [PTR_W-1:0] sched_wp, sched_rp;
	logic             sched_ovf, sched_running;
	logic             sched_fire;
	logic [LEN_W-1:0] sched_len;

	assign item_stall = (state_q == ST_READ) || (res_valid_q && result_stall);
	assign accept     = item_valid && !item_stall;

	// item decode
	assign is_write = (func == FUNC_WRITE);
	assign is_done  = (func == FUNC_DONE);
	assign is_read  = (func == FUNC_READ);
	assign wp_inc   = (wp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign wr_hit   = (wp_inc == rp_q);
	assign done_rp  = (snap_q > rp_q) ? snap_q : '0;
	assign wr_ok    = is_write && !ovf_q;
	assign done_msg = is_done && running_q && ovf_q && !warn_q;
	assign done_adv = is_done && running_q && !done_msg;

	// read address range check and memory index
	assign addr_wide   = AW'(read_address);
	assign rd_in_range = {1'b0, addr_wide} < (AW + 1)'(BUFFER_DEPTH);
	assign rd_index    = addr_wide[PTR_W-1:0];

	// scheduler operands: a write sees the advanced write pointer, a done the
	// advanced read pointer with overflow already cleared
	assign sched_try     = (wr_ok && (end_of_write || wr_hit)) || done_adv;
	assign sched_wp      = is_write ? wp_inc : wp_q;
	assign sched_rp      = done_adv ? done_rp : rp_q;
	assign sched_ovf     = is_write ? (ovf_q || wr_hit) : 1'b0;
	assign sched_running = is_write ? running_q : 1'b0;

	// burst scheduler: from read pointer to write pointer or to the buffer end
	always_comb begin
		sched_fire = sched_try && !sched_running && !((sched_wp == sched_rp) && !sched_ovf);
		if (sched_wp > sched_rp) begin
			sched_len = LEN_W'(sched_wp - sched_rp);
		end else begin
			sched_len = LEN_W'(BUFFER_DEPTH) - LEN_W'(sched_rp);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			snap_q    <= '0;
			running_q <= 1'b0;
			ovf_q     <= 1'b0;
			warn_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			snap_q    <= snap_d;
			running_q <= running_d;
			ovf_q     <= ovf_d;
			warn_q    <= warn_d;
		end
	end

	// next state, pointer updates and result values
	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		snap_d    = snap_q;
		running_d = running_q;
		ovf_d     = ovf_q;
		warn_d    = warn_q;
		mem_we    = 1'b0;
		mem_addr  = wp_q;
		out_load  = 1'b0;
		nx_wr_acc = 1'b0;
		nx_start  = 1'b0;
		nx_msg    = 1'b0;
		nx_offset = '0;
		nx_length = '0;
		nx_rdata  = '0;
		nx_ovf    = ovf_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_read) begin
						mem_addr = rd_index;
						state_d  = ST_READ;
					end else begin
						out_load = 1'b1;
						if (wr_ok) begin
							mem_we = 1'b1;
							wp_d   = wp_inc;
							ovf_d  = ovf_q || wr_hit;
						end
						if (done_msg) begin
							warn_d = 1'b1;
						end
						if (done_adv) begin
							running_d = 1'b0;
							rp_d      = done_rp;
							ovf_d     = 1'b0;
							warn_d    = 1'b0;
						end
						if (sched_fire) begin
							snap_d    = sched_wp;
							running_d = 1'b1;
						end
						nx_wr_acc = wr_ok;
						nx_start  = sched_fire || done_msg;
						nx_msg    = done_msg;
						nx_offset = sched_fire ? OFFSET_W'(sched_rp) : '0;
						if (done_msg) begin
							nx_length = WARN_LENGTH;
						end else if (sched_fire) begin
							nx_length = LENGTH_W'(sched_len);
						end
						nx_ovf = ovf_d;
					end
				end
			end
			ST_READ: begin
				out_load = 1'b1;
				nx_rdata = rd_in_range_q ? rdata_q : '0;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// single-port byte store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			byte_store_mem[mem_addr] <= data_byte;
		end
		rdata_q <= byte_store_mem[mem_addr];
	end

	// read range flag travels with the pending read
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_in_range_q <= rd_in_range;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_wr_acc_q <= nx_wr_acc;
			res_ovf_q    <= nx_ovf;
			res_start_q  <= nx_start;
			res_msg_q    <= nx_msg;
			res_offset_q <= nx_offset;
			res_length_q <= nx_length;
			res_rdata_q  <= nx_rdata;
		end
	end

	assign result_valid     = res_valid_q;
	assign write_accepted   = res_wr_acc_q;
	assign overflow_flag    = res_ovf_q;
	assign start_burst      = res_start_q;
	assign burst_is_message = res_msg_q;
	assign burst_offset     = res_offset_q;
	assign burst_length     = res_length_q;
	assign read_data        = res_rdata_q;

endmodule

>>> design/txrb_checker.sv
// port checker for the transmit ring buffer dma chunker, bound to the top level
`include "tx_ring_buffer_dma_chunker_macros.svh"

module txrb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic                            start_burst,
	input logic                            burst_is_message,
	input logic [txrb_pkg::OFFSET_W-1:0]   burst_offset,
	input logic [txrb_pkg::LENGTH_W-1:0]   burst_length,
	input logic [txrb_pkg::BYTE_W-1:0]     read_data
);
	import txrb_pkg::*;

	// a stalled result beat holds
	`TXRB_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(burst_length) && $stable(burst_offset) && $stable(read_data), "stalled result beat changed")

	// warning burst is fixed length at offset zero
	`TXRB_ASSERT_NOW(a_msg_shape, result_valid && burst_is_message, start_burst && (burst_length == WARN_LENGTH) && (burst_offset == '0), "bad warning burst")

	// a data burst always carries bytes
	`TXRB_ASSERT_NOW(a_burst_len, result_valid && start_burst, burst_length != '0, "empty burst issued")

	// no burst fields without a burst
	`TXRB_ASSERT_NOW(a_no_burst, result_valid && !start_burst, !burst_is_message && (burst_length == '0) && (burst_offset == '0), "burst fields set without a burst")

endmodule

bind tx_ring_buffer_dma_chunker txrb_checker u_txrb_checker (.*);
